// ----- src/serial_message_deframer_top_defines.svh -----
// ----------------------------------------------------------------------------
// Serial message deframer assertion macros
// Concurrent check wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SERIAL_MESSAGE_DEFRAMER_TOP_DEFINES_SVH
`define SERIAL_MESSAGE_DEFRAMER_TOP_DEFINES_SVH

`ifndef SYNTHESIS
`define SMD_ASSERT_IMP(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("smd check failed");
`define SMD_ASSERT_NXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("smd check failed");
`else
`define SMD_ASSERT_IMP(name, ante, cons)
`define SMD_ASSERT_NXT(name, ante, cons)
`endif

`endif

// ----- src/smd_pkg.sv -----
// ----------------------------------------------------------------------------
// Serial message deframer package
// Shared types, codes and reset constants.
// ----------------------------------------------------------------------------
`default_nettype none

package smd_pkg;

    localparam int unsigned MAX_BODY_DEFAULT = 128;

    localparam logic [7:0] START_CODE_RESET = 8'h1B;
    localparam logic [7:0] TOKEN_CODE_RESET = 8'h0E;

    localparam int unsigned CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] REG_START_CODE = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TOKEN_CODE = 2'd1;

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_SEQ    = 3'd1,
        PH_LEN_HI = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_TOKEN  = 3'd4,
        PH_BODY   = 3'd5,
        PH_CHECK  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_END   = 2'd1,
        KIND_ABORT = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       rx_error;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  data_byte;
        logic [6:0]  body_index;
        logic [7:0]  frame_seq;
        logic [15:0] body_length;
        logic        checksum_ok;
        logic        truncated;
    } result_t;

endpackage

`default_nettype wire

// ----- src/smd_in_reg.sv -----
// ----------------------------------------------------------------------------
// Serial message deframer input register
// Holds one received byte until the frame logic takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_in_reg (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_stall,
    input  wire smd_pkg::item_t item_in,
    input  wire logic          res_block,
    output logic               step,
    output smd_pkg::item_t     item_out
);
    import smd_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  accept;

    assign in_stall = valid_reg && res_block;
    assign accept   = in_valid && !in_stall;
    assign step     = valid_reg && !res_block;
    assign item_out = item_reg;

    always_comb
    begin
        if (accept)
            valid_next = 1'b1;
        else if (step)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            item_reg <= item_in;
    end

endmodule

`default_nettype wire

// ----- src/smd_core.sv -----
// ----------------------------------------------------------------------------
// Serial message deframer frame logic
// Phase state machine, header capture, body count and running XOR.
// ----------------------------------------------------------------------------
`default_nettype none
`include "serial_message_deframer_top_defines.svh"

module smd_core #(
    parameter int unsigned MAX_BODY = smd_pkg::MAX_BODY_DEFAULT
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           step,
    input  wire smd_pkg::item_t item,
    input  wire logic [7:0]     start_code,
    input  wire logic [7:0]     token_code,
    output logic                res_fire,
    output smd_pkg::result_t    res
);
    import smd_pkg::*;

    phase_t      phase_reg;
    phase_t      phase_next;
    logic [7:0]  seq_reg;
    logic [7:0]  seq_next;
    logic [15:0] length_reg;
    logic [15:0] length_next;
    logic [15:0] count_reg;
    logic [15:0] count_next;
    logic [7:0]  xor_reg;
    logic [7:0]  xor_next;
    logic [15:0] count_inc;
    logic [7:0]  xor_upd;
    logic        pos_stored;
    logic        over_cap;

    assign count_inc  = count_reg + 16'd1;
    assign xor_upd    = xor_reg ^ item.rx_byte;
    assign pos_stored = {1'b0, count_reg} < 17'(MAX_BODY);
    assign over_cap   = {1'b0, length_reg} > 17'(MAX_BODY);

    always_comb
    begin
        phase_next = phase_reg;
        if (step)
        begin
            if (item.rx_error)
                phase_next = PH_HUNT;
            else
            begin
                unique case (phase_reg)
                    PH_HUNT:   phase_next = (item.rx_byte == start_code) ? PH_SEQ : PH_HUNT;
                    PH_SEQ:    phase_next = PH_LEN_HI;
                    PH_LEN_HI: phase_next = PH_LEN_LO;
                    PH_LEN_LO: phase_next = PH_TOKEN;
                    PH_TOKEN:
                    begin
                        if (item.rx_byte != token_code)
                            phase_next = PH_HUNT;
                        else if (length_reg == 16'd0)
                            phase_next = PH_CHECK;
                        else
                            phase_next = PH_BODY;
                    end
                    PH_BODY:   phase_next = (count_inc >= length_reg) ? PH_CHECK : PH_BODY;
                    PH_CHECK:  phase_next = PH_HUNT;
                    default:   phase_next = PH_HUNT;
                endcase
            end
        end
    end

    always_comb
    begin
        seq_next          = seq_reg;
        length_next       = length_reg;
        count_next        = count_reg;
        xor_next          = xor_reg;
        res_fire          = 1'b0;
        res               = '0;
        res.frame_seq     = seq_reg;
        res.body_length   = length_reg;
        if (step)
        begin
            if (item.rx_error)
            begin
                if (phase_reg == PH_BODY || phase_reg == PH_CHECK)
                begin
                    res_fire = 1'b1;
                    res.kind = KIND_ABORT;
                end
            end
            else
            begin
                case (phase_reg)
                    PH_HUNT:
                    begin
                        if (item.rx_byte == start_code)
                            xor_next = item.rx_byte;
                    end
                    PH_SEQ:
                    begin
                        seq_next = item.rx_byte;
                        xor_next = xor_upd;
                    end
                    PH_LEN_HI:
                    begin
                        length_next = {item.rx_byte, 8'd0};
                        xor_next    = xor_upd;
                    end
                    PH_LEN_LO:
                    begin
                        length_next = {length_reg[15:8], item.rx_byte};
                        xor_next    = xor_upd;
                    end
                    PH_TOKEN:
                    begin
                        if (item.rx_byte == token_code)
                        begin
                            xor_next   = xor_upd;
                            count_next = 16'd0;
                        end
                    end
                    PH_BODY:
                    begin
                        xor_next   = xor_upd;
                        count_next = count_inc;
                        if (pos_stored)
                        begin
                            res_fire       = 1'b1;
                            res.kind       = KIND_BODY;
                            res.data_byte  = item.rx_byte;
                            res.body_index = count_reg[6:0];
                        end
                    end
                    PH_CHECK:
                    begin
                        xor_next        = xor_upd;
                        res_fire        = 1'b1;
                        res.kind        = KIND_END;
                        res.checksum_ok = (xor_upd == 8'd0);
                        res.truncated   = over_cap;
                    end
                    default:
                    begin
                        xor_next = xor_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HUNT;
            seq_reg    <= 8'd0;
            length_reg <= 16'd0;
            count_reg  <= 16'd0;
            xor_reg    <= 8'd0;
        end
        else
        begin
            phase_reg  <= phase_next;
            seq_reg    <= seq_next;
            length_reg <= length_next;
            count_reg  <= count_next;
            xor_reg    <= xor_next;
        end
    end

    `SMD_ASSERT_IMP(a_end_from_check,
        res_fire && res.kind == KIND_END, phase_reg == PH_CHECK && !item.rx_error)
    `SMD_ASSERT_NXT(a_check_closes, step && phase_reg == PH_CHECK, phase_reg == PH_HUNT)
    `SMD_ASSERT_NXT(a_error_hunts, step && item.rx_error, phase_reg == PH_HUNT)
    `SMD_ASSERT_IMP(a_body_in_body,
        res_fire && res.kind == KIND_BODY, phase_reg == PH_BODY && count_reg < length_reg)

endmodule

`default_nettype wire

// ----- src/smd_out_reg.sv -----
// ----------------------------------------------------------------------------
// Serial message deframer result register
// Holds one result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module smd_out_reg (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             load,
    input  wire smd_pkg::result_t res_in,
    input  wire logic             out_stall,
    output logic                  out_valid,
    output logic                  res_block,
    output smd_pkg::result_t      res_out
);
    import smd_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign out_valid = valid_reg;
    assign res_block = valid_reg && out_stall;
    assign res_out   = res_reg;

    always_comb
    begin
        if (load)
            valid_next = 1'b1;
        else if (res_block)
            valid_next = 1'b1;
        else
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (load)
            res_reg <= res_in;
    end

endmodule

`default_nettype wire

// ----- src/serial_message_deframer_top.sv -----
// ----------------------------------------------------------------------------
// Serial message deframer
// Finds framed messages in a received byte stream and reports body bytes,
// frame ends and aborts. One byte is taken every cycle unless in_stall is
// high; a byte passes an input register and the frame state update, and
// its result (if any) is loaded into the result register and shown there.
// Throughput is one byte per cycle while the input is not stalled; the
// input stalls only while a held result is stalled.
// Configuration writes are always ready and take effect on the next byte.
// ----------------------------------------------------------------------------
`default_nettype none

module serial_message_deframer_top #(
    parameter int unsigned MAX_BODY = smd_pkg::MAX_BODY_DEFAULT
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire logic [7:0]                      rx_byte,
    input  wire logic                            rx_error,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output logic [1:0]                           kind,
    output logic [7:0]                           data_byte,
    output logic [6:0]                           body_index,
    output logic [7:0]                           frame_seq,
    output logic [15:0]                          body_length,
    output logic                                 checksum_ok,
    output logic                                 truncated,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [smd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [7:0]                      cfg_data
);
    import smd_pkg::*;

    logic [7:0] start_code_reg;
    logic [7:0] token_code_reg;
    item_t      item_in;
    item_t      item_s1;
    logic       step;
    logic       res_block;
    logic       res_fire;
    result_t    res_core;
    result_t    res_out;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_code_reg <= START_CODE_RESET;
            token_code_reg <= TOKEN_CODE_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_START_CODE: start_code_reg <= cfg_data;
                REG_TOKEN_CODE: token_code_reg <= cfg_data;
                default:
                begin
                    start_code_reg <= start_code_reg;
                end
            endcase
        end
    end

    assign item_in.rx_byte  = rx_byte;
    assign item_in.rx_error = rx_error;

    smd_in_reg u_in_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .item_in   (item_in),
        .res_block (res_block),
        .step      (step),
        .item_out  (item_s1)
    );

    smd_core #(
        .MAX_BODY (MAX_BODY)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .item       (item_s1),
        .start_code (start_code_reg),
        .token_code (token_code_reg),
        .res_fire   (res_fire),
        .res        (res_core)
    );

    smd_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_fire),
        .res_in    (res_core),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .res_block (res_block),
        .res_out   (res_out)
    );

    assign kind        = res_out.kind;
    assign data_byte   = res_out.data_byte;
    assign body_index  = res_out.body_index;
    assign frame_seq   = res_out.frame_seq;
    assign body_length = res_out.body_length;
    assign checksum_ok = res_out.checksum_ok;
    assign truncated   = res_out.truncated;

endmodule

`default_nettype wire
